/* rtl/core/tsrr_pkg.sv */
// tsrr_pkg: shared types and constants of the shortest-root replacer
// datapath command codes, controller status bundle and field codes
// no dependencies
package tsrr_pkg;

  localparam int SYM_W  = 5;
  localparam int FUNC_W = 2;

  localparam int DEF_NODES    = 256;
  localparam int DEF_ALPHABET = 26;

  localparam logic [SYM_W-1:0]  SPACE_CODE  = 5'd26;

  localparam logic [FUNC_W-1:0] FN_INSERT   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_SENTENCE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_CLEAR    = 2'd2;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LATCH,
    DP_CLEAR,
    DP_RD_INS,
    DP_INS_STEP,
    DP_ZERO_NEW,
    DP_RD_MARK,
    DP_MARK,
    DP_END_WORD,
    DP_RD_MATCH,
    DP_MATCH_STEP,
    DP_EMIT
  } dp_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              letter_ok;
    logic              last;
    logic              ins_dropped;
    logic              ins_at_root;
    logic              word_matched;
    logic              word_missed;
    logic              child_found;
    logic              pool_full;
    logic              out_free;
  } dp_status_t;

endpackage

/* rtl/core/tsrr_datapath.sv */
// tsrr_datapath: node row memory, cursors, word flags and output register
// one row per node holds every child pointer with its terminal mark
// depends on tsrr_pkg
module tsrr_datapath #(
  parameter int NODES    = tsrr_pkg::DEF_NODES,
  parameter int ALPHABET = tsrr_pkg::DEF_ALPHABET
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tsrr_pkg::dp_cmd_t             cmd,
  output tsrr_pkg::dp_status_t          status,
  input  logic [tsrr_pkg::FUNC_W-1:0]   in_func,
  input  logic [tsrr_pkg::SYM_W-1:0]    in_symbol,
  input  logic                          in_last,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          has_symbol,
  output logic [tsrr_pkg::SYM_W-1:0]    out_symbol,
  output logic                          out_last,
  output logic                          overflow
);
  import tsrr_pkg::*;

  localparam int NW = $clog2(NODES);
  localparam int LW = $clog2(ALPHABET);

  // entry: terminal mark on top, child pointer below, zero pointer means none
  typedef logic [NW:0] entry_t;
  typedef entry_t [ALPHABET-1:0] row_t;

  row_t mem [NODES];
  row_t rdata;

  logic [FUNC_W-1:0] item_func;
  logic [SYM_W-1:0]  item_sym;
  logic              item_last;

  logic [NW-1:0] ins_cursor;
  logic [NW-1:0] ins_parent;
  logic [LW-1:0] ins_letter;
  logic          ins_dropped;
  logic [NW-1:0] new_node;
  logic [NW:0]   next_free;

  logic [NW-1:0] match_cursor;
  logic          word_matched;
  logic          word_missed;
  logic          ovf_flag;

  logic [LW-1:0] letter;
  entry_t        entry;
  logic [NW-1:0] child_ptr;
  logic          child_term;
  logic          child_found;
  logic          pool_full;
  logic          is_space;
  logic          letter_ok;
  logic          emit_keep;
  logic          out_load;
  logic          load_keep;
  logic          out_free;

  logic          mem_we;
  logic          mem_re;
  logic [NW-1:0] mem_addr;
  row_t          mem_wdata;

  assign letter      = LW'(item_sym);
  assign entry       = rdata[letter];
  assign child_ptr   = entry[NW-1:0];
  assign child_term  = entry[NW];
  assign child_found = (child_ptr != '0);
  assign pool_full   = (next_free >= (NW+1)'(NODES));
  assign is_space    = (item_sym == SPACE_CODE);
  assign letter_ok   = !is_space && (32'(item_sym) < ALPHABET);
  assign emit_keep   = is_space || (letter_ok && !word_matched);
  assign out_load    = (cmd == DP_MATCH_STEP) || (cmd == DP_EMIT);
  assign load_keep   = (cmd == DP_MATCH_STEP) || emit_keep;
  assign out_free    = !out_valid || out_ready;

  assign status.func         = item_func;
  assign status.letter_ok    = letter_ok;
  assign status.last         = item_last;
  assign status.ins_dropped  = ins_dropped;
  assign status.ins_at_root  = (ins_cursor == '0);
  assign status.word_matched = word_matched;
  assign status.word_missed  = word_missed;
  assign status.child_found  = child_found;
  assign status.pool_full    = pool_full;
  assign status.out_free     = out_free;

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = '0;
    mem_wdata = rdata;
    unique case (cmd)
      DP_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
      end
      DP_RD_INS: begin
        mem_re   = 1'b1;
        mem_addr = ins_cursor;
      end
      DP_INS_STEP: begin
        mem_addr = ins_cursor;
        if (child_found) begin
          mem_we                = item_last;
          mem_wdata[letter][NW] = 1'b1;
        end else if (!pool_full) begin
          mem_we            = 1'b1;
          mem_wdata[letter] = {item_last, next_free[NW-1:0]};
        end
      end
      DP_ZERO_NEW: begin
        mem_we    = 1'b1;
        mem_addr  = new_node;
        mem_wdata = '0;
      end
      DP_RD_MARK: begin
        mem_re   = 1'b1;
        mem_addr = ins_parent;
      end
      DP_MARK: begin
        mem_we                    = 1'b1;
        mem_addr                  = ins_parent;
        mem_wdata[ins_letter][NW] = 1'b1;
      end
      DP_RD_MATCH: begin
        mem_re   = 1'b1;
        mem_addr = match_cursor;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ins_cursor   <= '0;
      ins_dropped  <= 1'b0;
      next_free    <= (NW+1)'(1);
      match_cursor <= '0;
      word_matched <= 1'b0;
      word_missed  <= 1'b0;
      ovf_flag     <= 1'b0;
      out_valid    <= 1'b0;
      overflow     <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        overflow  <= ovf_flag;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (cmd)
        DP_CLEAR: begin
          ins_cursor   <= '0;
          ins_dropped  <= 1'b0;
          next_free    <= (NW+1)'(1);
          match_cursor <= '0;
          word_matched <= 1'b0;
          word_missed  <= 1'b0;
        end
        DP_INS_STEP: begin
          if (child_found) begin
            if (item_last) begin
              ins_cursor  <= '0;
              ins_dropped <= 1'b0;
            end else begin
              ins_cursor <= child_ptr;
            end
          end else if (pool_full) begin
            ovf_flag <= 1'b1;
            if (item_last) begin
              ins_cursor  <= '0;
              ins_dropped <= 1'b0;
            end else begin
              ins_dropped <= 1'b1;
            end
          end else begin
            next_free  <= next_free + (NW+1)'(1);
            ins_cursor <= item_last ? '0 : next_free[NW-1:0];
          end
        end
        DP_MARK, DP_END_WORD: begin
          ins_cursor  <= '0;
          ins_dropped <= 1'b0;
        end
        DP_MATCH_STEP: begin
          if (item_last) begin
            match_cursor <= '0;
            word_matched <= 1'b0;
            word_missed  <= 1'b0;
          end else if (!child_found) begin
            word_missed <= 1'b1;
          end else begin
            match_cursor <= child_ptr;
            word_matched <= child_term;
          end
        end
        DP_EMIT: begin
          if (is_space || item_last) begin
            match_cursor <= '0;
            word_matched <= 1'b0;
            word_missed  <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == DP_LATCH) begin
      item_func <= in_func;
      item_sym  <= in_symbol;
      item_last <= in_last;
    end
    if ((cmd == DP_INS_STEP) && (child_found || !pool_full)) begin
      ins_parent <= ins_cursor;
      ins_letter <= letter;
      new_node   <= next_free[NW-1:0];
    end
    if (out_load) begin
      has_symbol <= load_keep;
      out_symbol <= load_keep ? item_sym : '0;
      out_last   <= item_last;
    end
  end

endmodule

/* rtl/core/tsrr_ctrl.sv */
// tsrr_ctrl: sequencer for one word at a time
// issues datapath commands from its state and the datapath status
// depends on tsrr_pkg
module tsrr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tsrr_pkg::dp_status_t status,
  output tsrr_pkg::dp_cmd_t    cmd
);
  import tsrr_pkg::*;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_RUN,
    S_INS_STEP,
    S_ZERO,
    S_MARK_WR,
    S_MATCH_STEP
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = DP_NOP;
    unique case (state)
      S_INIT: begin
        cmd        = DP_CLEAR;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd        = DP_LATCH;
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        unique case (status.func)
          FN_INSERT: begin
            if (status.letter_ok && !status.ins_dropped) begin
              cmd        = DP_RD_INS;
              state_next = S_INS_STEP;
            end else if (status.last && !status.ins_dropped && !status.ins_at_root) begin
              cmd        = DP_RD_MARK;
              state_next = S_MARK_WR;
            end else if (status.last) begin
              cmd        = DP_END_WORD;
              state_next = S_IDLE;
            end else begin
              state_next = S_IDLE;
            end
          end
          FN_SENTENCE: begin
            if (status.letter_ok && !status.word_matched && !status.word_missed) begin
              cmd        = DP_RD_MATCH;
              state_next = S_MATCH_STEP;
            end else if (status.out_free) begin
              cmd        = DP_EMIT;
              state_next = S_IDLE;
            end
          end
          FN_CLEAR: begin
            cmd        = DP_CLEAR;
            state_next = S_IDLE;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_INS_STEP: begin
        cmd = DP_INS_STEP;
        if (!status.child_found && !status.pool_full) begin
          state_next = S_ZERO;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_ZERO: begin
        cmd        = DP_ZERO_NEW;
        state_next = S_IDLE;
      end
      S_MARK_WR: begin
        cmd        = DP_MARK;
        state_next = S_IDLE;
      end
      S_MATCH_STEP: begin
        if (status.out_free) begin
          cmd        = DP_MATCH_STEP;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/core/trie_shortest_root_replacer_top.sv */
// sentence items load out_valid, a trie walk in the match step after a row read, others in
// the emit step, once the output register is free; one word at a time through the single
// port of the node row memory (dictionary letter: latch, read, insert, zero a new node)
// reset: clears control state, then writes an empty root row before ready rises
// node rows are zeroed when their node is allocated; overflow stays set until reset
// top level of the shortest-root replacer, joins tsrr_ctrl and tsrr_datapath, uses tsrr_pkg
module trie_shortest_root_replacer_top #(
  parameter int NODES    = tsrr_pkg::DEF_NODES,
  parameter int ALPHABET = tsrr_pkg::DEF_ALPHABET
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tsrr_pkg::FUNC_W-1:0]  func,
  input  logic [tsrr_pkg::SYM_W-1:0]   symbol,
  input  logic                         last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         has_symbol,
  output logic [tsrr_pkg::SYM_W-1:0]   out_symbol,
  output logic                         out_last,
  output logic                         overflow
);
  import tsrr_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  tsrr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tsrr_datapath #(
    .NODES    (NODES),
    .ALPHABET (ALPHABET)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .in_func    (func),
    .in_symbol  (symbol),
    .in_last    (last),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .has_symbol (has_symbol),
    .out_symbol (out_symbol),
    .out_last   (out_last),
    .overflow   (overflow)
  );

  a_overflow_sticky: assert property (@(posedge clk) disable iff (rst)
    overflow |=> overflow)
    else $error("overflow flag fell");

  a_one_word_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word taken while one is in work");

  a_result_only_for_sentence: assert property (@(posedge clk) disable iff (rst)
    (cmd == DP_MATCH_STEP || cmd == DP_EMIT) |-> (status.func == FN_SENTENCE))
    else $error("result produced for a non-sentence word");

  a_no_output_overrun: assert property (@(posedge clk) disable iff (rst)
    (cmd == DP_MATCH_STEP || cmd == DP_EMIT) |-> status.out_free)
    else $error("output register overwritten before taken");

endmodule

/* test/tsrr_root_checker.sv */
// tsrr_root_checker: watches both channels of the shortest-root replacer, predicts
// each output word from its own copy of the trie and compares field by field
// depends on tsrr_pkg
module tsrr_root_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [tsrr_pkg::FUNC_W-1:0]  func,
  input  logic [tsrr_pkg::SYM_W-1:0]   symbol,
  input  logic                         last,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic                         has_symbol,
  input  logic [tsrr_pkg::SYM_W-1:0]   out_symbol,
  input  logic                         out_last,
  input  logic                         overflow,
  output int                           pending,
  output int                           fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import tsrr_pkg::*;

  localparam int NODES    = DEF_NODES;
  localparam int ALPHABET = DEF_ALPHABET;
  localparam int NODE_W   = $clog2(NODES);

  typedef logic [NODE_W-1:0] node_t;

  typedef struct packed {
    logic             has_sym;
    logic [SYM_W-1:0] sym;
    logic             lst;
    logic             ovf;
  } root_word_t;

  node_t           child_tbl [NODES*ALPHABET];
  logic            term_bits [NODES];
  logic [NODE_W:0] free_node;
  node_t           ins_node;
  logic            ins_drop;
  node_t           walk_node;
  logic            walk_hit;
  logic            walk_off;
  logic            ovf_seen;
  root_word_t      kept_q [$];

  function automatic void restart_walk();
    walk_node = '0;
    walk_hit  = 1'b0;
    walk_off  = 1'b0;
  endfunction

  function automatic void wipe_dict();
    for (int i = 0; i < NODES*ALPHABET; i++) child_tbl[i] = '0;
    for (int i = 0; i < NODES; i++) term_bits[i] = 1'b0;
    free_node = (NODE_W+1)'(1);
    ins_node  = '0;
    ins_drop  = 1'b0;
    restart_walk();
  endfunction

  function automatic void add_letter(logic [SYM_W-1:0] s, logic l);
    int    slot;
    node_t child;
    if (!ins_drop && s < ALPHABET && s != SPACE_CODE) begin
      slot  = int'(ins_node) * ALPHABET + int'(s);
      child = child_tbl[slot];
      if (child == '0) begin
        if (free_node >= NODES) begin
          ins_drop = 1'b1;
          ovf_seen = 1'b1;
        end else begin
          child = node_t'(free_node);
          child_tbl[slot] = child;
          term_bits[child] = 1'b0;
          free_node = free_node + 1'b1;
        end
      end
      if (!ins_drop) ins_node = child;
    end
    if (l) begin
      if (!ins_drop) term_bits[ins_node] = 1'b1;
      ins_node = '0;
      ins_drop = 1'b0;
    end
  endfunction

  function automatic void walk_symbol(logic [SYM_W-1:0] s, logic l);
    root_word_t w;
    logic       keep;
    node_t      child;
    keep = 1'b0;
    if (s == SPACE_CODE) begin
      keep = 1'b1;
      restart_walk();
    end else if (s < ALPHABET) begin
      if (walk_hit) begin
        keep = 1'b0;
      end else if (walk_off) begin
        keep = 1'b1;
      end else begin
        child = child_tbl[int'(walk_node) * ALPHABET + int'(s)];
        keep  = 1'b1;
        if (child == '0) begin
          walk_off = 1'b1;
        end else begin
          walk_node = child;
          if (term_bits[child]) walk_hit = 1'b1;
        end
      end
    end
    if (l) restart_walk();
    w.has_sym = keep;
    w.sym     = keep ? s : '0;
    w.lst     = l;
    w.ovf     = ovf_seen;
    kept_q.push_back(w);
  endfunction

  always @(posedge clk) begin : watch
    root_word_t w;
    if (rst) begin
      wipe_dict();
      ovf_seen   = 1'b0;
      fail_count = 0;
      kept_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (kept_q.size() == 0) begin
          $error("output word with no expected result");
          fail_count++;
        end else begin
          w = kept_q.pop_front();
          if (has_symbol !== w.has_sym) begin
            $error("has_symbol expected %0d actual %0d", w.has_sym, has_symbol);
            fail_count++;
          end
          if (out_symbol !== w.sym) begin
            $error("out_symbol expected %0d actual %0d", w.sym, out_symbol);
            fail_count++;
          end
          if (out_last !== w.lst) begin
            $error("out_last expected %0d actual %0d", w.lst, out_last);
            fail_count++;
          end
          if (overflow !== w.ovf) begin
            $error("overflow expected %0d actual %0d", w.ovf, overflow);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        case (func)
          FN_INSERT:   add_letter(symbol, last);
          FN_SENTENCE: walk_symbol(symbol, last);
          FN_CLEAR:    wipe_dict();
          default:     ;
        endcase
      end
    end
    pending <= kept_q.size();
  end

endmodule

/* test/tb_trie_shortest_root_replacer_top.sv */
// tb_trie_shortest_root_replacer_top: drives dictionary, sentence and clear words into
// the shortest-root replacer with random gaps and stalls, gives the verdict
// depends on tsrr_pkg, trie_shortest_root_replacer_top and tsrr_root_checker
module tb_trie_shortest_root_replacer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tsrr_pkg::*;

  localparam int ITEMS      = 1750;
  localparam int FLOOD_AT   = 1100;
  localparam int WATCHDOG   = 4000;
  localparam int HOLD_LEN   = 400;
  localparam int TAIL_WAIT  = 20;
  localparam int MAX_WORDS  = 40;
  localparam int MAX_LEN    = 8;

  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              in_valid   = 1'b0;
  logic              in_ready;
  logic [FUNC_W-1:0] func       = FN_INSERT;
  logic [SYM_W-1:0]  symbol     = '0;
  logic              last       = 1'b0;
  logic              out_valid;
  logic              out_ready  = 1'b0;
  logic              has_symbol;
  logic [SYM_W-1:0]  out_symbol;
  logic              out_last;
  logic              overflow;
  int                pending;
  int                fail_count;

  logic [SYM_W-1:0]  dict_sym [MAX_WORDS][MAX_LEN];
  int                dict_len [MAX_WORDS];
  int                dict_n = 0;
  int                items_sent = 0;
  int                letters_since_clear = 0;
  bit                src_burst = 1'b0;
  bit                flooded = 1'b0;

  always #4 clk = ~clk;

  trie_shortest_root_replacer_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .symbol     (symbol),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .has_symbol (has_symbol),
    .out_symbol (out_symbol),
    .out_last   (out_last),
    .overflow   (overflow)
  );

  tsrr_root_checker i_root_chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .symbol     (symbol),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .has_symbol (has_symbol),
    .out_symbol (out_symbol),
    .out_last   (out_last),
    .overflow   (overflow),
    .pending    (pending),
    .fail_count (fail_count)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [SYM_W-1:0] pick_letter(bit narrow);
    return narrow ? SYM_W'($urandom_range(3, 0)) : SYM_W'($urandom_range(25, 0));
  endfunction

  task automatic drive_word(input logic [FUNC_W-1:0] f, input logic [SYM_W-1:0] s,
                            input logic l);
    int g;
    g = src_burst ? 0 : pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    symbol   <= s;
    last     <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic insert_entry(input int idx);
    bit code_end;
    code_end = ($urandom_range(9, 0) == 0);
    for (int i = 0; i < dict_len[idx]; i++) begin
      if ($urandom_range(15, 0) == 0)
        drive_word(FN_INSERT, SYM_W'($urandom_range(31, SPACE_CODE)), 1'b0);
      drive_word(FN_INSERT, dict_sym[idx][i], (i == dict_len[idx] - 1) && !code_end);
    end
    if (code_end) drive_word(FN_INSERT, SYM_W'($urandom_range(31, SPACE_CODE)), 1'b1);
    letters_since_clear += dict_len[idx];
  endtask

  task automatic send_sentence();
    logic [SYM_W-1:0] seq [96];
    int n, nw, kind, idx, len;
    n  = 0;
    nw = $urandom_range(6, 1);
    for (int w = 0; w < nw; w++) begin
      if (w > 0) begin
        seq[n] = SPACE_CODE;
        n++;
        if ($urandom_range(7, 0) == 0) begin
          seq[n] = SPACE_CODE;
          n++;
        end
      end
      kind = (dict_n == 0) ? 9 : $urandom_range(9, 0);
      if (kind < 9) begin
        idx = $urandom_range(dict_n - 1, 0);
        len = dict_len[idx];
        if (kind == 5 || kind == 6) len = $urandom_range(len, 1);
        for (int i = 0; i < len; i++) begin
          seq[n] = dict_sym[idx][i];
          n++;
        end
        if (kind >= 7) begin
          repeat ($urandom_range(3, 1)) begin
            seq[n] = pick_letter(1'($urandom_range(1, 0)));
            n++;
          end
        end
      end else begin
        repeat ($urandom_range(6, 1)) begin
          seq[n] = pick_letter(1'($urandom_range(1, 0)));
          n++;
        end
      end
      if ($urandom_range(11, 0) == 0) begin
        seq[n] = SYM_W'($urandom_range(31, 27));
        n++;
      end
    end
    if ($urandom_range(7, 0) == 0) begin
      seq[n] = SPACE_CODE;
      n++;
    end
    for (int i = 0; i < n; i++) drive_word(FN_SENTENCE, seq[i], i == n - 1);
  endtask

  task automatic dict_round(input bit flood);
    int  nwords;
    bit  narrow;
    if (!flood && ($urandom_range(3, 0) != 0 || letters_since_clear > 150)) begin
      drive_word(FN_CLEAR, SYM_W'($urandom_range(31, 0)), 1'($urandom_range(1, 0)));
      letters_since_clear = 0;
    end
    src_burst = ($urandom_range(3, 0) == 0);
    nwords = flood ? MAX_WORDS : $urandom_range(12, 1);
    narrow = !flood && ($urandom_range(1, 0) == 1);
    for (int i = 0; i < nwords; i++) begin
      if (flood) dict_len[i] = MAX_LEN;
      else if ($urandom_range(3, 0) == 0) dict_len[i] = $urandom_range(MAX_LEN, 1);
      else dict_len[i] = $urandom_range(4, 1);
      for (int j = 0; j < dict_len[i]; j++) dict_sym[i][j] = pick_letter(narrow);
      insert_entry(i);
    end
    dict_n = nwords;
    if ($urandom_range(9, 0) == 0) drive_word(FN_INSERT, SYM_W'($urandom_range(31, 27)), 1'b1);
    if ($urandom_range(5, 0) == 0) begin
      repeat ($urandom_range(3, 1)) begin
        drive_word(FN_INSERT, pick_letter(narrow), 1'b0);
        letters_since_clear++;
      end
    end
    repeat ($urandom_range(4, 1)) begin
      send_sentence();
      if ($urandom_range(7, 0) == 0)
        drive_word(FN_UNUSED, SYM_W'($urandom_range(31, 0)), 1'($urandom_range(1, 0)));
    end
  endtask

  // sink side: random ready gaps, burst stretches and long hold-offs
  initial begin : sink
    int g, cyc, next_hold;
    bit burst;
    cyc       = 0;
    next_hold = 2500;
    burst     = 1'b0;
    @(posedge clk);
    forever begin
      if (cyc >= next_hold) begin
        g = HOLD_LEN;
        next_hold += 4500;
      end else begin
        g = burst ? 0 : pick_gap();
      end
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
        cyc += g;
      end
      out_ready <= 1'b1;
      @(posedge clk);
      cyc++;
      if ($urandom_range(199, 0) == 0) burst = !burst;
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty dictionary, word falls out of the trie
    drive_word(FN_SENTENCE, 5'd0, 1'b1);
    // dictionary: "ca", "z" ended by an invalid code, empty word
    drive_word(FN_INSERT, 5'd2, 1'b0);
    drive_word(FN_INSERT, 5'd0, 1'b1);
    drive_word(FN_INSERT, 5'd25, 1'b0);
    drive_word(FN_INSERT, SPACE_CODE, 1'b1);
    drive_word(FN_INSERT, 5'd31, 1'b1);
    // sentence "cat zz?b ba" with a dropped code inside
    drive_word(FN_SENTENCE, 5'd2, 1'b0);
    drive_word(FN_SENTENCE, 5'd0, 1'b0);
    drive_word(FN_SENTENCE, 5'd19, 1'b0);
    drive_word(FN_SENTENCE, SPACE_CODE, 1'b0);
    drive_word(FN_SENTENCE, 5'd25, 1'b0);
    drive_word(FN_SENTENCE, 5'd25, 1'b0);
    drive_word(FN_SENTENCE, 5'd31, 1'b0);
    drive_word(FN_SENTENCE, 5'd1, 1'b0);
    drive_word(FN_SENTENCE, SPACE_CODE, 1'b0);
    drive_word(FN_SENTENCE, 5'd1, 1'b0);
    drive_word(FN_SENTENCE, 5'd0, 1'b1);
    drive_word(FN_UNUSED, 5'd31, 1'b1);
    // end of sentence returns the walk to the root
    drive_word(FN_SENTENCE, 5'd2, 1'b1);
    drive_word(FN_SENTENCE, 5'd0, 1'b0);
    drive_word(FN_SENTENCE, SPACE_CODE, 1'b1);
    drive_word(FN_CLEAR, 5'd0, 1'b0);
    drive_word(FN_SENTENCE, 5'd2, 1'b0);
    drive_word(FN_SENTENCE, 5'd0, 1'b1);

    while (items_sent < ITEMS) begin
      if (!flooded && items_sent >= FLOOD_AT) begin
        flooded = 1'b1;
        dict_round(1'b1);
      end else begin
        dict_round(1'b0);
      end
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (TAIL_WAIT) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
